@@ rtl/core/rti_pkg.sv @@
package rti_pkg;

    localparam int DIR_W     = 32;
    localparam int EPS_W     = 16;
    localparam int DIST_W    = 31;
    localparam int TAG_W     = 32;
    localparam int WGT_W     = 32;
    localparam int FRAC_SH   = 30;
    localparam int QUOT_BITS = 42;
    localparam int RES_W     = 44;
    localparam int PRE_ST    = 7;

    localparam logic signed [RES_W-1:0] ONE_Q30  = RES_W'(64'sd1073741824);
    localparam logic signed [RES_W-1:0] QUOT_SAT = RES_W'(64'sd1099511627776);
    localparam logic signed [DIR_W-1:0] DIR_Z_RST = 32'sd1073741824;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPSILON  = 3'd6
    } t_reg_idx;

endpackage

@@ rtl/core/ray_triangle_intersect_unit.sv @@
// ray / triangle intersection unit (moller-trumbore, fixed point)
// the ray (origin q16.16, direction q2.30, epsilon) sits in apb registers;
// program them while no triangle is in flight
// input channel: drive one triangle beat with start high; busy is always low,
// so a new triangle may be issued on every clock cycle
// output channel: o_done is high for one cycle with hit, distance, the three
// barycentric weights and the tag; the receiver must take it in that cycle
// latency: results appear 49 cycles after the accepting edge, in issue order
// throughput: one triangle per cycle, set by the fully pipelined datapath:
// seven arithmetic stages (edges, cross products, split dot products,
// sums, magnitudes) then a 42-stage restoring divider, one quotient bit per
// stage, for u, v and distance side by side
// a miss returns zero distance and weights and still carries the tag
// reset: synchronous, clears the pipeline valid bits and sets the ray to
// origin zero, direction +z, epsilon one
module ray_triangle_intersect_unit
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_v0_x,
    input  logic signed [COORD_WIDTH-1:0] i_v0_y,
    input  logic signed [COORD_WIDTH-1:0] i_v0_z,
    input  logic signed [COORD_WIDTH-1:0] i_v1_x,
    input  logic signed [COORD_WIDTH-1:0] i_v1_y,
    input  logic signed [COORD_WIDTH-1:0] i_v1_z,
    input  logic signed [COORD_WIDTH-1:0] i_v2_x,
    input  logic signed [COORD_WIDTH-1:0] i_v2_y,
    input  logic signed [COORD_WIDTH-1:0] i_v2_z,
    input  logic [DIST_W-1:0]             i_max_distance,
    input  logic [TAG_W-1:0]              i_tri_tag,
    output logic                          o_done,
    output logic                          o_hit,
    output logic [DIST_W-1:0]             o_hit_distance,
    output logic signed [WGT_W-1:0]       o_weight_w0,
    output logic signed [WGT_W-1:0]       o_weight_u,
    output logic signed [WGT_W-1:0]       o_weight_v,
    output logic [TAG_W-1:0]              o_tag_out
);

    localparam int W    = COORD_WIDTH;
    localparam int PDW  = (W > 32) ? 64 : 32;
    localparam int ASH  = (W > 32) ? 3 : 2;
    localparam int AW   = ASH + 3;
    localparam int EW   = W + 1;
    localparam int DW   = DIR_W;
    localparam int PW   = DW + EW + 1;
    localparam int QW   = 2 * EW + 1;
    localparam int PL   = PW / 2;
    localparam int QL   = QW / 2;
    localparam int PF   = EW + PW;
    localparam int DQF  = DW + QW;
    localparam int EQF  = EW + QW;
    localparam int DETW = PF + 2;
    localparam int DQW  = DQF + 2;
    localparam int EQW  = EQF + 2;
    localparam int NW0  = (DETW > DQW) ? DETW : DQW;
    localparam int NW   = ((NW0 > EQW) ? NW0 : EQW) + FRAC_SH;
    localparam int QB   = QUOT_BITS;
    localparam int CW   = NW + QB;
    localparam int NS   = PRE_ST + QB;

    // configuration
    logic signed [W-1:0]  r_org [3];
    logic signed [DW-1:0] r_dir [3];
    logic [EPS_W-1:0]     r_eps;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[AW-1:ASH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= DIR_Z_RST;
            r_eps    <= EPS_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORIGIN_X: r_org[0] <= pwdata[W-1:0];
                REG_ORIGIN_Y: r_org[1] <= pwdata[W-1:0];
                REG_ORIGIN_Z: r_org[2] <= pwdata[W-1:0];
                REG_DIR_X:    r_dir[0] <= pwdata[DW-1:0];
                REG_DIR_Y:    r_dir[1] <= pwdata[DW-1:0];
                REG_DIR_Z:    r_dir[2] <= pwdata[DW-1:0];
                REG_EPSILON:  r_eps    <= pwdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ORIGIN_X: prdata = PDW'(r_org[0]);
            REG_ORIGIN_Y: prdata = PDW'(r_org[1]);
            REG_ORIGIN_Z: prdata = PDW'(r_org[2]);
            REG_DIR_X:    prdata = PDW'(r_dir[0]);
            REG_DIR_Y:    prdata = PDW'(r_dir[1]);
            REG_DIR_Z:    prdata = PDW'(r_dir[2]);
            REG_EPSILON:  prdata = PDW'(r_eps);
            default:      prdata = '0;
        endcase
    end

    // valid, tag and limit travel alongside the datapath
    logic              r_vld  [NS];
    logic [TAG_W-1:0]  r_tag  [NS];
    logic [DIST_W-1:0] r_maxd [NS];
    logic              in_acc;

    assign in_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= in_acc;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0]  <= i_tri_tag;
        r_maxd[0] <= i_max_distance;
        for (int k = 1; k < NS; k++) begin
            r_tag[k]  <= r_tag[k-1];
            r_maxd[k] <= r_maxd[k-1];
        end
    end

    // stage 1: edges and origin offset
    logic signed [EW-1:0] r1_e1 [3];
    logic signed [EW-1:0] r1_e2 [3];
    logic signed [EW-1:0] r1_tv [3];

    always_ff @(posedge i_clk) begin
        r1_e1[0] <= EW'(i_v1_x) - EW'(i_v0_x);
        r1_e1[1] <= EW'(i_v1_y) - EW'(i_v0_y);
        r1_e1[2] <= EW'(i_v1_z) - EW'(i_v0_z);
        r1_e2[0] <= EW'(i_v2_x) - EW'(i_v0_x);
        r1_e2[1] <= EW'(i_v2_y) - EW'(i_v0_y);
        r1_e2[2] <= EW'(i_v2_z) - EW'(i_v0_z);
        r1_tv[0] <= EW'(r_org[0]) - EW'(i_v0_x);
        r1_tv[1] <= EW'(r_org[1]) - EW'(i_v0_y);
        r1_tv[2] <= EW'(r_org[2]) - EW'(i_v0_z);
    end

    // stage 2: cross product terms, p = dir x e2, q = tv x e1
    logic signed [DW+EW-1:0] r2_pp [6];
    logic signed [2*EW-1:0]  r2_qp [6];
    logic signed [EW-1:0]    r2_e1 [3];
    logic signed [EW-1:0]    r2_e2 [3];
    logic signed [EW-1:0]    r2_tv [3];

    always_ff @(posedge i_clk) begin
        r2_pp[0] <= (DW+EW)'(r_dir[1]) * (DW+EW)'(r1_e2[2]);
        r2_pp[1] <= (DW+EW)'(r_dir[2]) * (DW+EW)'(r1_e2[1]);
        r2_pp[2] <= (DW+EW)'(r_dir[2]) * (DW+EW)'(r1_e2[0]);
        r2_pp[3] <= (DW+EW)'(r_dir[0]) * (DW+EW)'(r1_e2[2]);
        r2_pp[4] <= (DW+EW)'(r_dir[0]) * (DW+EW)'(r1_e2[1]);
        r2_pp[5] <= (DW+EW)'(r_dir[1]) * (DW+EW)'(r1_e2[0]);
        r2_qp[0] <= (2*EW)'(r1_tv[1]) * (2*EW)'(r1_e1[2]);
        r2_qp[1] <= (2*EW)'(r1_tv[2]) * (2*EW)'(r1_e1[1]);
        r2_qp[2] <= (2*EW)'(r1_tv[2]) * (2*EW)'(r1_e1[0]);
        r2_qp[3] <= (2*EW)'(r1_tv[0]) * (2*EW)'(r1_e1[2]);
        r2_qp[4] <= (2*EW)'(r1_tv[0]) * (2*EW)'(r1_e1[1]);
        r2_qp[5] <= (2*EW)'(r1_tv[1]) * (2*EW)'(r1_e1[0]);
        r2_e1 <= r1_e1;
        r2_e2 <= r1_e2;
        r2_tv <= r1_tv;
    end

    // stage 3: cross products
    logic signed [PW-1:0] r3_p [3];
    logic signed [QW-1:0] r3_q [3];
    logic signed [EW-1:0] r3_e1 [3];
    logic signed [EW-1:0] r3_e2 [3];
    logic signed [EW-1:0] r3_tv [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_p[i] <= PW'(r2_pp[2*i]) - PW'(r2_pp[2*i+1]);
            r3_q[i] <= QW'(r2_qp[2*i]) - QW'(r2_qp[2*i+1]);
        end
        r3_e1 <= r2_e1;
        r3_e2 <= r2_e2;
        r3_tv <= r2_tv;
    end

    // stage 4: dot product terms split into low and high halves
    logic signed [EW+PL:0]     r4_det_lo [3];
    logic signed [EW+PW-PL-1:0] r4_det_hi [3];
    logic signed [EW+PL:0]     r4_tp_lo  [3];
    logic signed [EW+PW-PL-1:0] r4_tp_hi  [3];
    logic signed [DW+QL:0]     r4_dq_lo  [3];
    logic signed [DW+QW-QL-1:0] r4_dq_hi  [3];
    logic signed [EW+QL:0]     r4_eq_lo  [3];
    logic signed [EW+QW-QL-1:0] r4_eq_hi  [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_det_lo[i] <= (EW+PL+1)'(r3_e1[i]) * (EW+PL+1)'($signed({1'b0, r3_p[i][PL-1:0]}));
            r4_det_hi[i] <= (EW+PW-PL)'(r3_e1[i]) * (EW+PW-PL)'($signed(r3_p[i][PW-1:PL]));
            r4_tp_lo[i]  <= (EW+PL+1)'(r3_tv[i]) * (EW+PL+1)'($signed({1'b0, r3_p[i][PL-1:0]}));
            r4_tp_hi[i]  <= (EW+PW-PL)'(r3_tv[i]) * (EW+PW-PL)'($signed(r3_p[i][PW-1:PL]));
            r4_dq_lo[i]  <= (DW+QL+1)'(r_dir[i]) * (DW+QL+1)'($signed({1'b0, r3_q[i][QL-1:0]}));
            r4_dq_hi[i]  <= (DW+QW-QL)'(r_dir[i]) * (DW+QW-QL)'($signed(r3_q[i][QW-1:QL]));
            r4_eq_lo[i]  <= (EW+QL+1)'(r3_e2[i]) * (EW+QL+1)'($signed({1'b0, r3_q[i][QL-1:0]}));
            r4_eq_hi[i]  <= (EW+QW-QL)'(r3_e2[i]) * (EW+QW-QL)'($signed(r3_q[i][QW-1:QL]));
        end
    end

    // stage 5: recombine halves
    logic signed [PF-1:0]  r5_det [3];
    logic signed [PF-1:0]  r5_tp  [3];
    logic signed [DQF-1:0] r5_dq  [3];
    logic signed [EQF-1:0] r5_eq  [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_det[i] <= (PF'(r4_det_hi[i]) <<< PL) + PF'(r4_det_lo[i]);
            r5_tp[i]  <= (PF'(r4_tp_hi[i]) <<< PL) + PF'(r4_tp_lo[i]);
            r5_dq[i]  <= (DQF'(r4_dq_hi[i]) <<< QL) + DQF'(r4_dq_lo[i]);
            r5_eq[i]  <= (EQF'(r4_eq_hi[i]) <<< QL) + EQF'(r4_eq_lo[i]);
        end
    end

    // stage 6: dot product sums
    logic signed [DETW-1:0] r6_det;
    logic signed [DETW-1:0] r6_tp;
    logic signed [DQW-1:0]  r6_dq;
    logic signed [EQW-1:0]  r6_eq;

    always_ff @(posedge i_clk) begin
        r6_det <= DETW'(r5_det[0]) + DETW'(r5_det[1]) + DETW'(r5_det[2]);
        r6_tp  <= DETW'(r5_tp[0]) + DETW'(r5_tp[1]) + DETW'(r5_tp[2]);
        r6_dq  <= DQW'(r5_dq[0]) + DQW'(r5_dq[1]) + DQW'(r5_dq[2]);
        r6_eq  <= EQW'(r5_eq[0]) + EQW'(r5_eq[1]) + EQW'(r5_eq[2]);
    end

    // stage 7: magnitudes, quotient signs, determinant test
    logic [DETW-1:0] n7_den;
    logic [DETW-1:0] n7_atp;
    logic [DQW-1:0]  n7_adq;
    logic [EQW-1:0]  n7_aeq;

    logic [NW-1:0]   r_rem [QB+1][3];
    logic [QB-1:0]   r_q   [QB+1][3];
    logic [DETW-1:0] r_den [QB+1];
    logic [2:0]      r_neg [QB+1];
    logic            r_small [QB+1];

    always_comb begin
        n7_den = r6_det[DETW-1] ? DETW'(-r6_det) : DETW'(r6_det);
        n7_atp = r6_tp[DETW-1] ? DETW'(-r6_tp) : DETW'(r6_tp);
        n7_adq = r6_dq[DQW-1] ? DQW'(-r6_dq) : DQW'(r6_dq);
        n7_aeq = r6_eq[EQW-1] ? EQW'(-r6_eq) : EQW'(r6_eq);
    end

    // restoring divider, one quotient bit per stage, msb (overflow) first
    logic [NW-1:0] n_rem [QB][3];
    logic [QB-1:0] n_q   [QB][3];
    logic [CW-1:0] n_sub [QB];

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_sub[k] = CW'(r_den[k]) << (QB - 1 - k);
            for (int j = 0; j < 3; j++) begin
                n_rem[k][j] = r_rem[k][j];
                n_q[k][j]   = r_q[k][j];
                if (CW'(r_rem[k][j]) >= n_sub[k]) begin
                    n_rem[k][j] = r_rem[k][j] - n_sub[k][NW-1:0];
                    n_q[k][j][QB-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0]    <= n7_den;
        r_small[0]  <= (n7_den <= DETW'(r_eps));
        r_rem[0][0] <= NW'(n7_atp) << FRAC_SH;
        r_rem[0][1] <= NW'(n7_adq) << FRAC_SH;
        r_rem[0][2] <= NW'(n7_aeq) << FRAC_SH;
        r_q[0][0]   <= '0;
        r_q[0][1]   <= '0;
        r_q[0][2]   <= '0;
        r_neg[0]    <= {r6_eq[EQW-1] ^ r6_det[DETW-1],
                        r6_dq[DQW-1] ^ r6_det[DETW-1],
                        r6_tp[DETW-1] ^ r6_det[DETW-1]};
        for (int k = 0; k < QB; k++) begin
            r_rem[k+1]   <= n_rem[k];
            r_q[k+1]     <= n_q[k];
            r_den[k+1]   <= r_den[k];
            r_neg[k+1]   <= r_neg[k];
            r_small[k+1] <= r_small[k];
        end
    end

    // final checks
    logic signed [RES_W-1:0] n_qs [3];
    logic signed [RES_W-1:0] n_eps;
    logic signed [RES_W-1:0] n_hi_lim;
    logic signed [RES_W-1:0] n_uv;
    logic signed [RES_W-1:0] n_w0;
    logic                    n_hit;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_q[QB][j][QB-1] || (RES_W'(r_q[QB][j][QB-2:0]) > QUOT_SAT)) begin
                n_qs[j] = QUOT_SAT;
            end else begin
                n_qs[j] = RES_W'(r_q[QB][j][QB-2:0]);
            end
            if (r_neg[QB][j]) begin
                n_qs[j] = -n_qs[j];
            end
        end
        n_eps    = RES_W'(r_eps);
        n_hi_lim = ONE_Q30 + n_eps;
        n_uv     = n_qs[0] + n_qs[1];
        n_w0     = ONE_Q30 - n_uv;
        n_hit    = !r_small[QB]
                && !(n_qs[0] < -n_eps) && !(n_qs[0] > n_hi_lim)
                && !(n_qs[1] < -n_eps) && !(n_uv > n_hi_lim)
                && (n_qs[2] > n_eps) && (n_qs[2] < RES_W'(r_maxd[NS-1]));
    end

    // output beat
    logic                    r_done;
    logic                    r_hit;
    logic [DIST_W-1:0]       r_dist;
    logic signed [WGT_W-1:0] r_w0;
    logic signed [WGT_W-1:0] r_wu;
    logic signed [WGT_W-1:0] r_wv;
    logic [TAG_W-1:0]        r_tag_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_done <= r_vld[NS-1];
            r_hit  <= r_vld[NS-1] && n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_out <= r_tag[NS-1];
        if (n_hit) begin
            r_dist <= n_qs[2][DIST_W-1:0];
            r_w0   <= n_w0[WGT_W-1:0];
            r_wu   <= n_qs[0][WGT_W-1:0];
            r_wv   <= n_qs[1][WGT_W-1:0];
        end else begin
            r_dist <= '0;
            r_w0   <= '0;
            r_wu   <= '0;
            r_wv   <= '0;
        end
    end

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;
    assign o_weight_w0    = r_w0;
    assign o_weight_u     = r_wu;
    assign o_weight_v     = r_wv;
    assign o_tag_out      = r_tag_out;

    a_hit_only_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> !o_hit)
        else $error("hit without result beat");

    a_hit_dist_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (o_hit_distance != '0))
        else $error("hit with zero distance");

    a_weights_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (WGT_W'(o_weight_w0 + o_weight_u + o_weight_v) == WGT_W'(ONE_Q30)))
        else $error("barycentric weights do not sum to one");

    a_beat_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[NS-1]))
        else $error("result beat without issued triangle");

endmodule

@@ bench/ray_triangle_intersect_unit_test.sv @@
`timescale 1ns / 1ps

module ray_triangle_intersect_unit_test;
    import rti_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 215;
    localparam int NUM_PHASES     = 6;
    localparam logic signed [31:0] UNIT   = 32'sd65536;
    localparam logic signed [31:0] C_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX  = 32'sh7fff_ffff;
    localparam logic [30:0]        D_MAX  = 31'h7fff_ffff;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] v[9];
        logic [30:0]        maxd;
        logic [31:0]        tag;
    } tri_t;

    typedef struct {
        logic        hit;
        logic [30:0] span;
        logic [31:0] w0;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] tag;
    } isect_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        o_done;
    logic        o_hit;
    logic [30:0] o_hit_distance;
    logic signed [31:0] o_weight_w0, o_weight_u, o_weight_v;
    logic [31:0] o_tag_out;

    tri_t   cur;
    tri_t   tri_q[$];
    isect_t isect_q[$];
    logic   took;
    int     idle_pct;
    int     mismatches;
    int     quiet_cycles;

    logic signed [31:0] ray_org[3];
    logic signed [31:0] ray_dir[3];
    logic [15:0]        ray_eps;

    ray_triangle_intersect_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_v0_x         (cur.v[0]),
        .i_v0_y         (cur.v[1]),
        .i_v0_z         (cur.v[2]),
        .i_v1_x         (cur.v[3]),
        .i_v1_y         (cur.v[4]),
        .i_v1_z         (cur.v[5]),
        .i_v2_x         (cur.v[6]),
        .i_v2_y         (cur.v[7]),
        .i_v2_z         (cur.v[8]),
        .i_max_distance (cur.maxd),
        .i_tri_tag      (cur.tag),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_hit_distance (o_hit_distance),
        .o_weight_w0    (o_weight_w0),
        .o_weight_u     (o_weight_u),
        .o_weight_v     (o_weight_v),
        .o_tag_out      (o_tag_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic wide_t widen(logic signed [31:0] x);
        wide_t r;
        r = x;
        return r;
    endfunction

    function automatic void queue_tri(tri_t t);
        tri_q = {tri_q, t};
    endfunction

    // signed quotient truncated toward zero, saturated at 2^40
    function automatic logic signed [63:0] sat_quot(wide_t n, wide_t d);
        wide_t an, ad, m, lim;
        logic  neg;
        lim = 1;
        lim = lim <<< 40;
        an  = (n < 0) ? -n : n;
        ad  = (d < 0) ? -d : d;
        neg = (n < 0) != (d < 0);
        if (ad == 0) m = lim;
        else m = an / ad;
        if (m > lim) m = lim;
        return neg ? -m[63:0] : m[63:0];
    endfunction

    function automatic isect_t intersect_triangle(tri_t t);
        isect_t r;
        wide_t e1[3], e2[3], tv[3], d[3], p[3], q[3], det, adet;
        logic signed [63:0] u, v, span, one, eps;
        r = '{hit: 1'b0, span: '0, w0: '0, u: '0, v: '0, tag: t.tag};
        one = 64'sd1 <<< 30;
        eps = {48'd0, ray_eps};
        for (int i = 0; i < 3; i++) begin
            e1[i] = widen(t.v[3+i]) - widen(t.v[i]);
            e2[i] = widen(t.v[6+i]) - widen(t.v[i]);
            tv[i] = widen(ray_org[i]) - widen(t.v[i]);
            d[i]  = widen(ray_dir[i]);
        end
        p[0] = d[1] * e2[2] - d[2] * e2[1];
        p[1] = d[2] * e2[0] - d[0] * e2[2];
        p[2] = d[0] * e2[1] - d[1] * e2[0];
        det  = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        adet = (det < 0) ? -det : det;
        if (adet <= wide_t'(eps)) return r;
        u = sat_quot((tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2]) <<< 30, det);
        if (u < -eps || u > one + eps) return r;
        q[0] = tv[1] * e1[2] - tv[2] * e1[1];
        q[1] = tv[2] * e1[0] - tv[0] * e1[2];
        q[2] = tv[0] * e1[1] - tv[1] * e1[0];
        v = sat_quot((d[0] * q[0] + d[1] * q[1] + d[2] * q[2]) <<< 30, det);
        if (v < -eps || u + v > one + eps) return r;
        span = sat_quot((e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2]) <<< 30, det);
        if (span <= eps || span >= {33'd0, t.maxd}) return r;
        r.hit  = 1'b1;
        r.span = span[30:0];
        r.w0   = 32'(one - u - v);
        r.u    = u[31:0];
        r.v    = v[31:0];
        return r;
    endfunction

    function automatic tri_t make_tri(logic signed [31:0] a0, a1, a2, b0, b1, b2,
                                      logic signed [31:0] c0, c1, c2,
                                      logic [30:0] maxd, logic [31:0] tag);
        tri_t t;
        t.v  = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        t.maxd = maxd;
        t.tag  = tag;
        return t;
    endfunction

    function automatic tri_t noise_tri();
        tri_t t;
        for (int i = 0; i < 9; i++) t.v[i] = $urandom;
        t.maxd = 31'($urandom);
        t.tag  = $urandom;
        return t;
    endfunction

    // triangle around a point on the current ray, centroid on the ray
    function automatic tri_t aimed_tri();
        tri_t t;
        longint reach, spread, pt[3], a[3], b[3];
        reach  = $urandom_range(1 << 24, 1 << 10);
        spread = 1 << $urandom_range(22, 6);
        for (int i = 0; i < 3; i++) begin
            pt[i] = longint'(ray_org[i]) + ((reach * longint'(ray_dir[i])) >>> 30);
            a[i]  = longint'($urandom_range(2 * spread)) - spread;
            b[i]  = longint'($urandom_range(2 * spread)) - spread;
            t.v[i]   = 32'(pt[i] + a[i]);
            t.v[3+i] = 32'(pt[i] + b[i]);
            t.v[6+i] = 32'(pt[i] - a[i] - b[i]);
        end
        case ($urandom_range(3))
            0: t.maxd = D_MAX;
            1: t.maxd = 31'(reach + $urandom_range(255));
            2: t.maxd = 31'(reach / 2);
            default: t.maxd = 31'(reach * 2);
        endcase
        t.tag = $urandom;
        return t;
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ORIGIN_X: ray_org[0] = val;
            REG_ORIGIN_Y: ray_org[1] = val;
            REG_ORIGIN_Z: ray_org[2] = val;
            REG_DIR_X:    ray_dir[0] = val;
            REG_DIR_Y:    ray_dir[1] = val;
            REG_DIR_Z:    ray_dir[2] = val;
            REG_EPSILON:  ray_eps    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (tri_q.size() != 0 || start || isect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_ray(int phase);
        real dx, dy, dz, n;
        logic [31:0] o[3], dv[3];
        logic [15:0] eps;
        for (int i = 0; i < 3; i++) o[i] = $urandom_range(1 << 27) - (1 << 26);
        dx = $itor($urandom_range(2000)) - 1000.0;
        dy = $itor($urandom_range(2000)) - 1000.0;
        dz = $itor($urandom_range(2000)) - 1000.0;
        n  = $sqrt(dx * dx + dy * dy + dz * dz);
        if (n < 1.0) begin
            dz = 1.0;
            n  = 1.0;
        end
        dv[0] = $rtoi(dx / n * 1073741824.0);
        dv[1] = $rtoi(dy / n * 1073741824.0);
        dv[2] = $rtoi(dz / n * 1073741824.0);
        eps = 16'($urandom_range(64));
        if (phase == 0) eps = 16'd0;
        if (phase == NUM_PHASES - 1) begin
            o   = '{C_MIN, C_MAX, 32'sd0};
            dv  = '{C_MAX, C_MIN, 32'sd0};
            eps = 16'hffff;
        end else if (phase == 3) begin
            dv = '{32'sd0, 32'sd0, (($urandom_range(1)) ? 32'sh4000_0000 : 32'shc000_0000)};
        end
        apb_write(REG_ORIGIN_X, o[0]);
        apb_write(REG_ORIGIN_Y, o[1]);
        apb_write(REG_ORIGIN_Z, o[2]);
        apb_write(REG_DIR_X, dv[0]);
        apb_write(REG_DIR_Y, dv[1]);
        apb_write(REG_DIR_Z, dv[2]);
        apb_write(REG_EPSILON, {16'd0, eps});
    endtask

    initial begin
        tri_t t;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        took     = 1'b0;
        idle_pct = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 9; i++) cur.v[i] = '0;
        cur.maxd = '0;
        cur.tag  = '0;
        ray_org  = '{32'sd0, 32'sd0, 32'sd0};
        ray_dir  = '{32'sd0, 32'sd0, DIR_Z_RST};
        ray_eps  = 16'd1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed triangles against the reset ray
        queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, D_MAX, 32'h0));
        queue_tri(make_tri(-UNIT, -UNIT, 5 * UNIT, 3 * UNIT, -UNIT, 5 * UNIT,
                           -UNIT, 3 * UNIT, 5 * UNIT, D_MAX, 32'h0));
        queue_tri(make_tri(-UNIT, -UNIT, 5 * UNIT, -UNIT, 3 * UNIT, 5 * UNIT,
                           3 * UNIT, -UNIT, 5 * UNIT, D_MAX, 32'hffff_ffff));
        queue_tri(make_tri(-UNIT, -UNIT, 5 * UNIT, 3 * UNIT, -UNIT, 5 * UNIT,
                           -UNIT, 3 * UNIT, 5 * UNIT, 31'(5 * UNIT), 32'h1));
        queue_tri(make_tri(-UNIT, -UNIT, 5 * UNIT, 3 * UNIT, -UNIT, 5 * UNIT,
                           -UNIT, 3 * UNIT, 5 * UNIT, 31'(5 * UNIT + 1), 32'h2));
        queue_tri(make_tri(-UNIT, -UNIT, 5 * UNIT, 3 * UNIT, -UNIT, 5 * UNIT,
                           -UNIT, 3 * UNIT, 5 * UNIT, 31'd0, 32'h3));
        queue_tri(make_tri(-UNIT, -UNIT, -5 * UNIT, 3 * UNIT, -UNIT, -5 * UNIT,
                           -UNIT, 3 * UNIT, -5 * UNIT, D_MAX, 32'h4));
        queue_tri(make_tri(0, 0, 5 * UNIT, UNIT, 0, 5 * UNIT,
                           0, UNIT, 5 * UNIT, D_MAX, 32'h5));
        queue_tri(make_tri(-UNIT, 0, 5 * UNIT, UNIT, 0, 5 * UNIT,
                           -UNIT, 2 * UNIT, 5 * UNIT, D_MAX, 32'h6));
        queue_tri(make_tri(UNIT, 0, 5 * UNIT, 0, UNIT, 5 * UNIT,
                           -UNIT, -UNIT, 5 * UNIT, D_MAX, 32'h7));
        queue_tri(make_tri(0, -UNIT, 0, 0, UNIT, 0, 0, 0, UNIT, D_MAX, 32'h8));
        queue_tri(make_tri(-UNIT, -UNIT, 1, UNIT, -UNIT, 1,
                           -UNIT, UNIT, 1, D_MAX, 32'h9));
        queue_tri(make_tri(-UNIT, -UNIT, 2, UNIT, -UNIT, 2,
                           -UNIT, UNIT, 2, D_MAX, 32'ha));
        queue_tri(make_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                           C_MIN, C_MIN, C_MIN, D_MAX, 32'hb));
        queue_tri(make_tri(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                           C_MIN, C_MAX, C_MAX, D_MAX, 32'hc));
        queue_tri(make_tri(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN,
                           C_MAX, C_MIN, C_MIN, D_MAX, 32'hd));
        queue_tri(make_tri(C_MIN, 0, C_MIN, C_MAX, 1, C_MAX,
                           C_MIN, C_MAX, C_MAX, D_MAX, 32'he));
        queue_tri(make_tri(-UNIT, -1, 0, UNIT, -1, 1,
                           0, 1, C_MAX, D_MAX, 32'hf));
        queue_tri(make_tri(-UNIT, -UNIT, C_MAX, UNIT, -UNIT, C_MAX,
                           -UNIT, UNIT, C_MAX, D_MAX, 32'h10));
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_ray(phase);
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 88;
                default: idle_pct = 26;
            endcase
            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                case ($urandom_range(9))
                    0, 1: t = noise_tri();
                    2: begin
                        t = aimed_tri();
                        t.v[$urandom_range(8)] = $urandom;
                    end
                    default: t = aimed_tri();
                endcase
                queue_tri(t);
            end
            drain();
        end

        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // driver: one triangle beat per accepted start
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (tri_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur = tri_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // acceptance, result check and watchdog
    always @(posedge i_clk) begin
        isect_t exp_r;
        took <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) isect_q = {isect_q, intersect_triangle(cur)};
        if (i_rst_n && o_done) begin
            if (isect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat, tag %h", o_tag_out);
            end else begin
                exp_r = isect_q.pop_front();
                if (o_hit !== exp_r.hit || o_hit_distance !== exp_r.span ||
                    o_weight_w0 !== exp_r.w0 || o_weight_u !== exp_r.u ||
                    o_weight_v !== exp_r.v || o_tag_out !== exp_r.tag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit %b d %h w0 %h u %h v %h tag %h | got %b %h %h %h %h %h",
                                 exp_r.hit, exp_r.span, exp_r.w0, exp_r.u, exp_r.v, exp_r.tag,
                                 o_hit, o_hit_distance, o_weight_w0, o_weight_u, o_weight_v,
                                 o_tag_out);
                end
            end
        end
        if ((start && !busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
